@@ rtl/core/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg: shared types, constants and helpers for the LED chase sequencer
// Effect codes, register indexes, timing constants and LED mask helpers.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int NUM_LEDS   = 16;
  localparam int IDX_W      = $clog2(NUM_LEDS);
  localparam int POS_W      = $clog2(NUM_LEDS + 1);
  localparam int CNT_W      = 5;
  localparam int MODE_W     = 4;
  localparam int BLINK_W    = 8;
  localparam int PHASE_W    = 2;
  localparam int TIMER_W    = 10;
  localparam int REG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_W-1:0] LED_COUNT_RST = CNT_W'(8);

  // Timing in 1 ms ticks
  localparam int RT_CYCLES = 1800;
  localparam int RT_OFF_US = 49;
  localparam logic [TIMER_W-1:0] STEP_MS       = TIMER_W'(100);
  localparam logic [TIMER_W-1:0] BLINK_OFF_MS  = TIMER_W'(300);
  localparam logic [TIMER_W-1:0] BLINK_ON_MS   = TIMER_W'(500);
  localparam logic [TIMER_W-1:0] FLASH_TAIL_MS = TIMER_W'(300);
  localparam logic [TIMER_W-1:0] RT_STEP_MS    =
    TIMER_W'((RT_CYCLES * (1 + RT_OFF_US)) / 1000);

  typedef enum logic [MODE_W-1:0] {
    MODE_ON_ALL     = 4'd0,
    MODE_OFF_ALL    = 4'd1,
    MODE_FILL_UP    = 4'd2,
    MODE_FILL_DOWN  = 4'd3,
    MODE_CLEAR_UP   = 4'd4,
    MODE_CLEAR_DOWN = 4'd5,
    MODE_BLINK      = 4'd6,
    MODE_FLASH_UP   = 4'd7,
    MODE_FLASH_DOWN = 4'd8,
    MODE_ROUND_TRIP = 4'd9,
    MODE_STACK_HIGH = 4'd10,
    MODE_STACK_LOW  = 4'd11
  } lcs_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LED_COUNT  = 1'b0,
    REG_ACTIVE_LOW = 1'b1
  } lcs_reg_e;

  // Live configuration seen by the effect engine
  typedef struct packed {
    logic [POS_W-1:0]    n;
    logic [NUM_LEDS-1:0] use_mask;
    logic                active_low;
  } lcs_cfg_t;

  typedef struct packed {
    logic               start_req;
    logic [MODE_W-1:0]  mode;
    logic [BLINK_W-1:0] blink_count;
  } lcs_item_t;

  typedef struct packed {
    logic [NUM_LEDS-1:0] pin_levels;
    logic [NUM_LEDS-1:0] dim_mask;
    logic                busy_res;
    logic                done_res;
  } lcs_res_t;

  // One-hot of LED k, empty when k is off the bank
  function automatic logic [NUM_LEDS-1:0] bit_of(input logic [POS_W:0] k);
    logic [NUM_LEDS-1:0] m;
    m = '0;
    if (k < (POS_W+1)'(NUM_LEDS)) m[k[IDX_W-1:0]] = 1'b1;
    return m;
  endfunction

  // Lowest n LEDs
  function automatic logic [NUM_LEDS-1:0] all_of(input logic [POS_W-1:0] n);
    logic [NUM_LEDS-1:0] m;
    for (int i = 0; i < NUM_LEDS; i++) m[i] = (POS_W'(i) < n);
    return m;
  endfunction

  function automatic logic is_mirrored(input logic [MODE_W-1:0] eff);
    return (eff == MODE_FILL_DOWN) || (eff == MODE_CLEAR_DOWN) ||
           (eff == MODE_FLASH_DOWN) || (eff == MODE_STACK_LOW);
  endfunction

  // Step k of an effect, counted from the far end when mirrored
  function automatic logic [NUM_LEDS-1:0] led_at(input logic [POS_W-1:0] k,
                                                 input logic [POS_W-1:0] n,
                                                 input logic             mir);
    logic [NUM_LEDS-1:0] m;
    logic [POS_W-1:0]    idx;
    m   = '0;
    idx = mir ? (n - k - POS_W'(1)) : k;
    if (k < n) m = bit_of({1'b0, idx});
    return m;
  endfunction

endpackage

@@ rtl/core/lcs_req_if.sv @@
// ----------------------------------------------------------------------------
// lcs_req_if: request channel of the LED chase sequencer
// Start or tick requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         start_req;
  logic [lcs_pkg::MODE_W-1:0]   mode;
  logic [lcs_pkg::BLINK_W-1:0]  blink_count;

  modport source (output valid, start_req, mode, blink_count, input ready);
  modport sink   (input valid, start_req, mode, blink_count, output ready);
endinterface

@@ rtl/core/lcs_res_if.sv @@
// ----------------------------------------------------------------------------
// lcs_res_if: result channel of the LED chase sequencer
// Pin levels, dim flags and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcs_res_if;
  logic                          valid;
  logic                          ready;
  logic [lcs_pkg::NUM_LEDS-1:0]  pin_levels;
  logic [lcs_pkg::NUM_LEDS-1:0]  dim_mask;
  logic                          busy_res;
  logic                          done_res;

  modport source (output valid, pin_levels, dim_mask, busy_res, done_res,
                  input ready);
  modport sink   (input valid, pin_levels, dim_mask, busy_res, done_res,
                  output ready);
endinterface

@@ rtl/core/lcs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lcs_cfg_if: register write channel of the LED chase sequencer
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lcs_pkg::REG_IDX_W-1:0]   index;
  logic [lcs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/lcs_cfg.sv @@
// ----------------------------------------------------------------------------
// lcs_cfg: configuration registers
// Holds led_count and active_low; derives the clamped LED count and use mask.
// ----------------------------------------------------------------------------
module lcs_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [lcs_pkg::REG_IDX_W-1:0]     idx_i,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]    data_i,
  output lcs_pkg::lcs_cfg_t                 cfg_o
);

  logic [lcs_pkg::CNT_W-1:0] count_q, count_d;
  logic                      active_low_q, active_low_d;
  logic [lcs_pkg::POS_W-1:0] n_clamped;

  always_comb begin
    count_d      = count_q;
    active_low_d = active_low_q;
    if (we_i) begin
      case (idx_i)
        lcs_pkg::REG_LED_COUNT:  count_d      = data_i[lcs_pkg::CNT_W-1:0];
        lcs_pkg::REG_ACTIVE_LOW: active_low_d = data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= lcs_pkg::LED_COUNT_RST;
      active_low_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      active_low_q <= active_low_d;
    end
  end

  // zero reads as one LED, oversize as the full bank
  always_comb begin
    if (count_q == '0) begin
      n_clamped = lcs_pkg::POS_W'(1);
    end else if (count_q > lcs_pkg::CNT_W'(lcs_pkg::NUM_LEDS)) begin
      n_clamped = lcs_pkg::POS_W'(lcs_pkg::NUM_LEDS);
    end else begin
      n_clamped = lcs_pkg::POS_W'(count_q);
    end
  end

  assign cfg_o.n          = n_clamped;
  assign cfg_o.use_mask   = lcs_pkg::all_of(n_clamped);
  assign cfg_o.active_low = active_low_q;

endmodule

@@ rtl/core/lcs_engine.sv @@
// ----------------------------------------------------------------------------
// lcs_engine: effect state and single-pass step logic
// Applies one start or tick request to the effect state and forms its result.
// ----------------------------------------------------------------------------
module lcs_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  lcs_pkg::lcs_item_t  item_i,
  input  lcs_pkg::lcs_cfg_t   cfg_i,
  output lcs_pkg::lcs_res_t   res_o
);

  logic [lcs_pkg::NUM_LEDS-1:0] mask_q, mask_d;
  logic [lcs_pkg::MODE_W-1:0]   effect_q, effect_d;
  logic [lcs_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [lcs_pkg::POS_W-1:0]    pass_q, pass_d;
  logic [lcs_pkg::BLINK_W-1:0]  blinks_q, blinks_d;
  logic [lcs_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic [lcs_pkg::TIMER_W-1:0]  timer_q, timer_d;
  logic                         running_q, running_d;
  logic                         done;
  logic                         mir_start, mir_run;
  logic [lcs_pkg::POS_W-1:0]    last;
  logic [lcs_pkg::BLINK_W-1:0]  blinks_dec;
  logic [lcs_pkg::NUM_LEDS-1:0] lv, dim;

  // bright LED at p, its neighbours go dark
  function automatic logic [lcs_pkg::NUM_LEDS-1:0] rt_enter(
      input logic [lcs_pkg::NUM_LEDS-1:0] m,
      input logic [lcs_pkg::POS_W-1:0]    p);
    logic [lcs_pkg::NUM_LEDS-1:0] r;
    r = m;
    if (p != '0) r = r & ~lcs_pkg::bit_of({1'b0, p - lcs_pkg::POS_W'(1)});
    r = r & ~lcs_pkg::bit_of({1'b0, p} + (lcs_pkg::POS_W+1)'(1));
    r = r | lcs_pkg::bit_of({1'b0, p});
    return r;
  endfunction

  assign mir_start = lcs_pkg::is_mirrored(item_i.mode);
  assign mir_run   = lcs_pkg::is_mirrored(effect_q);

  always_comb begin
    mask_d     = mask_q;
    effect_d   = effect_q;
    pos_d      = pos_q;
    pass_d     = pass_q;
    blinks_d   = blinks_q;
    phase_d    = phase_q;
    timer_d    = timer_q;
    running_d  = running_q;
    done       = 1'b0;
    last       = '0;
    blinks_dec = (blinks_q != '0) ? blinks_q - lcs_pkg::BLINK_W'(1) : '0;

    if (fire_i) begin
      if (item_i.start_req) begin
        // start is dropped while an effect runs
        if (!running_q) begin
          effect_d = item_i.mode;
          pos_d    = '0;
          pass_d   = '0;
          phase_d  = '0;
          timer_d  = lcs_pkg::STEP_MS;
          case (item_i.mode)
            lcs_pkg::MODE_ON_ALL: begin
              mask_d = mask_q | cfg_i.use_mask;
              done   = 1'b1;
            end
            lcs_pkg::MODE_OFF_ALL: begin
              mask_d = mask_q & ~cfg_i.use_mask;
              done   = 1'b1;
            end
            lcs_pkg::MODE_FILL_UP, lcs_pkg::MODE_FILL_DOWN,
            lcs_pkg::MODE_FLASH_UP, lcs_pkg::MODE_FLASH_DOWN,
            lcs_pkg::MODE_STACK_HIGH, lcs_pkg::MODE_STACK_LOW: begin
              mask_d = mask_q | lcs_pkg::led_at('0, cfg_i.n, mir_start);
            end
            lcs_pkg::MODE_CLEAR_UP, lcs_pkg::MODE_CLEAR_DOWN: begin
              mask_d = mask_q & ~lcs_pkg::led_at('0, cfg_i.n, mir_start);
            end
            lcs_pkg::MODE_BLINK: begin
              if (item_i.blink_count == '0) begin
                done = 1'b1;
              end else begin
                blinks_d = item_i.blink_count;
                mask_d   = mask_q & ~cfg_i.use_mask;
                timer_d  = lcs_pkg::BLINK_OFF_MS;
              end
            end
            lcs_pkg::MODE_ROUND_TRIP: begin
              if (cfg_i.n < lcs_pkg::POS_W'(3)) begin
                done = 1'b1;
              end else begin
                pos_d   = lcs_pkg::POS_W'(1);
                mask_d  = rt_enter(mask_q, lcs_pkg::POS_W'(1));
                timer_d = lcs_pkg::RT_STEP_MS;
              end
            end
            default: done = 1'b1;
          endcase
          running_d = !done;
        end
      end else if (running_q) begin
        if (timer_q > lcs_pkg::TIMER_W'(1)) begin
          timer_d = timer_q - lcs_pkg::TIMER_W'(1);
        end else begin
          // step timer ran out
          case (effect_q)
            lcs_pkg::MODE_FILL_UP, lcs_pkg::MODE_FILL_DOWN,
            lcs_pkg::MODE_CLEAR_UP, lcs_pkg::MODE_CLEAR_DOWN: begin
              pos_d = pos_q + lcs_pkg::POS_W'(1);
              if (pos_d >= cfg_i.n) begin
                done = 1'b1;
              end else begin
                if (effect_q <= lcs_pkg::MODE_FILL_DOWN) begin
                  mask_d = mask_q | lcs_pkg::led_at(pos_d, cfg_i.n, mir_run);
                end else begin
                  mask_d = mask_q & ~lcs_pkg::led_at(pos_d, cfg_i.n, mir_run);
                end
                timer_d = lcs_pkg::STEP_MS;
              end
            end
            lcs_pkg::MODE_BLINK: begin
              if (phase_q == '0) begin
                mask_d  = mask_q | cfg_i.use_mask;
                phase_d = lcs_pkg::PHASE_W'(1);
                timer_d = lcs_pkg::BLINK_ON_MS;
              end else begin
                blinks_d = blinks_dec;
                if (blinks_dec == '0) begin
                  done = 1'b1;
                end else begin
                  mask_d  = mask_q & ~cfg_i.use_mask;
                  phase_d = '0;
                  timer_d = lcs_pkg::BLINK_OFF_MS;
                end
              end
            end
            lcs_pkg::MODE_FLASH_UP, lcs_pkg::MODE_FLASH_DOWN: begin
              if (phase_q != '0) begin
                done = 1'b1;
              end else begin
                mask_d = mask_q & ~lcs_pkg::led_at(pos_q, cfg_i.n, mir_run);
                pos_d  = pos_q + lcs_pkg::POS_W'(1);
                if (pos_d < cfg_i.n) begin
                  mask_d  = mask_d | lcs_pkg::led_at(pos_d, cfg_i.n, mir_run);
                  timer_d = lcs_pkg::STEP_MS;
                end else begin
                  // dark tail before the flash ends
                  phase_d = lcs_pkg::PHASE_W'(1);
                  timer_d = lcs_pkg::FLASH_TAIL_MS;
                end
              end
            end
            lcs_pkg::MODE_ROUND_TRIP: begin
              mask_d = mask_q & ~lcs_pkg::bit_of({1'b0, pos_q});
              if (pass_q == '0) begin
                if (({1'b0, pos_q} + (lcs_pkg::POS_W+1)'(2)) < {1'b0, cfg_i.n}) begin
                  pos_d = pos_q + lcs_pkg::POS_W'(1);
                end else begin
                  pass_d = lcs_pkg::POS_W'(1);
                end
                mask_d  = rt_enter(mask_d, pos_d);
                timer_d = lcs_pkg::RT_STEP_MS;
              end else if (pos_q <= lcs_pkg::POS_W'(1)) begin
                done = 1'b1;
              end else begin
                pos_d   = pos_q - lcs_pkg::POS_W'(1);
                mask_d  = rt_enter(mask_d, pos_d);
                timer_d = lcs_pkg::RT_STEP_MS;
              end
            end
            lcs_pkg::MODE_STACK_HIGH, lcs_pkg::MODE_STACK_LOW: begin
              if (pass_q >= cfg_i.n) begin
                done = 1'b1;
              end else begin
                last   = cfg_i.n - lcs_pkg::POS_W'(1) - pass_q;
                mask_d = mask_q & ~lcs_pkg::led_at(pos_q, cfg_i.n, mir_run);
                if (pos_q >= last) begin
                  // runner lands on top of the stack
                  mask_d = mask_d | lcs_pkg::led_at(last, cfg_i.n, mir_run);
                  pass_d = pass_q + lcs_pkg::POS_W'(1);
                  if (pass_d >= cfg_i.n) done = 1'b1;
                  else pos_d = '0;
                end else begin
                  pos_d = pos_q + lcs_pkg::POS_W'(1);
                end
                if (!done) begin
                  mask_d  = mask_d | lcs_pkg::led_at(pos_d, cfg_i.n, mir_run);
                  timer_d = lcs_pkg::STEP_MS;
                end
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      if (done) running_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      effect_q  <= '0;
      pos_q     <= '0;
      pass_q    <= '0;
      blinks_q  <= '0;
      phase_q   <= '0;
      timer_q   <= '0;
      running_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      effect_q  <= effect_d;
      pos_q     <= pos_d;
      pass_q    <= pass_d;
      blinks_q  <= blinks_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      running_q <= running_d;
    end
  end

  // result reflects the state after this request
  always_comb begin
    lv = mask_d & cfg_i.use_mask;
    if (cfg_i.active_low) lv = lv ^ cfg_i.use_mask;
    dim = '0;
    if (running_d && (effect_d == lcs_pkg::MODE_ROUND_TRIP)) begin
      if (pos_d != '0) dim = lcs_pkg::bit_of({1'b0, pos_d - lcs_pkg::POS_W'(1)});
      dim = dim | lcs_pkg::bit_of({1'b0, pos_d} + (lcs_pkg::POS_W+1)'(1));
      dim = dim & cfg_i.use_mask;
    end
  end

  assign res_o.pin_levels = lv;
  assign res_o.dim_mask   = dim;
  assign res_o.busy_res   = running_d;
  assign res_o.done_res   = done;

  a_run_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (timer_q != '0))
    else $error("running effect with empty step timer");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.done_res) |-> !res_o.busy_res)
    else $error("finished effect still reported busy");

  a_dim_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (res_o.dim_mask != '0)) |-> res_o.busy_res)
    else $error("dim flags while idle");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !item_i.start_req && !running_q) |=>
      ($stable(mask_q) && $stable(pos_q) && !running_q))
    else $error("idle tick changed effect state");

endmodule

@@ rtl/core/lcs_out_buf.sv @@
// ----------------------------------------------------------------------------
// lcs_out_buf: two-entry result buffer
// Result register plus skid entry; takes a result while the one ahead stalls.
// ----------------------------------------------------------------------------
module lcs_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lcs_pkg::lcs_res_t  data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_ready_i,
  output lcs_pkg::lcs_res_t  data_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  lcs_pkg::lcs_res_t main_q, main_d;
  lcs_pkg::lcs_res_t skid_q, skid_d;
  logic              pop;

  assign pop     = main_v_q && pop_ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!main_v_q || (pop && !skid_v_q)) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a result ahead of it");

endmodule

@@ rtl/core/led_chase_effect_sequencer.sv @@
// ----------------------------------------------------------------------------
// led_chase_effect_sequencer: timed LED effect sequencer
// Top level: configuration registers, effect engine and result buffer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i carries requests. start_req=1 starts the effect in mode (taken only
//    when idle, otherwise ignored); start_req=0 is one 1 ms tick that advances
//    the running effect. blink_count sets the number of blinks for blink mode.
//  - res_o returns exactly one result per request: pin levels after polarity,
//    the round-trip dim mask (neighbours of the bright LED, run at 1/50 duty
//    by the pin driver), busy and done flags.
//  - cfg_i writes led_count (index 0) and active_low (index 1); always ready.
//    Write only while idle. led_count is clamped to 1..NUM_LEDS and read live.
//  - Output: the result is registered in the result buffer and reaches res_o
//    once the results ahead of it are taken. Throughput: one request per
//    cycle while the buffer has room; each request is one pass of the step
//    logic between the effect state and the result register.
//  - Stall: a two-entry result buffer sits on the output. req_i.ready stays
//    high while a result waits, and drops only when both entries are full.
//  - Reset: all LEDs off, no effect running, led_count 8, active_high pins,
//    result buffer empty.
// ----------------------------------------------------------------------------
module led_chase_effect_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcs_req_if.sink   req_i,
  lcs_res_if.source res_o,
  lcs_cfg_if.sink   cfg_i
);

  lcs_pkg::lcs_cfg_t  cfg;
  lcs_pkg::lcs_item_t item;
  lcs_pkg::lcs_res_t  step_res;
  lcs_pkg::lcs_res_t  out_res;
  logic               cfg_we;
  logic               fire;
  logic               buf_ready;
  logic               buf_valid;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  lcs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  // request handshake: buffer room decides
  assign req_i.ready = buf_ready;
  assign fire        = req_i.valid && req_i.ready;

  assign item.start_req   = req_i.start_req;
  assign item.mode        = req_i.mode;
  assign item.blink_count = req_i.blink_count;

  lcs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  lcs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (step_res),
    .ready_o     (buf_ready),
    .valid_o     (buf_valid),
    .pop_ready_i (res_o.ready),
    .data_o      (out_res)
  );

  assign res_o.valid      = buf_valid;
  assign res_o.pin_levels = out_res.pin_levels;
  assign res_o.dim_mask   = out_res.dim_mask;
  assign res_o.busy_res   = out_res.busy_res;
  assign res_o.done_res   = out_res.done_res;

endmodule
